>>> design/bgd_pkg.sv
// Shared types and codes for the button gesture detector.
package bgd_pkg;

   localparam int unsigned CfgW = 16;

   typedef struct packed {
      logic [CfgW-1:0] click_ticks;
      logic [CfgW-1:0] press_ticks;
      logic [CfgW-1:0] debounce_ticks;
   } cfg_type;

   localparam logic [CfgW-1:0] ClickReset    = 16'd800;
   localparam logic [CfgW-1:0] PressReset    = 16'd1000;
   localparam logic [CfgW-1:0] DebounceReset = 16'd50;

   // register indexes on the csr port
   localparam logic [1:0] REG_CLICK    = 2'd0;
   localparam logic [1:0] REG_PRESS    = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE = 2'd2;

   // gesture codes
   localparam logic [2:0] GEST_NONE         = 3'd0;
   localparam logic [2:0] GEST_CLICK        = 3'd1;
   localparam logic [2:0] GEST_DOUBLE       = 3'd2;
   localparam logic [2:0] GEST_LONG_PRESS   = 3'd3;
   localparam logic [2:0] GEST_LONG_RELEASE = 3'd4;
   localparam logic [2:0] GEST_HELD_CLICK   = 3'd5;
   localparam logic [2:0] GEST_HELD_DOUBLE  = 3'd6;

   // gesture machine states
   localparam logic [3:0] ST_IDLE         = 4'd0;
   localparam logic [3:0] ST_PRESS1       = 4'd1;
   localparam logic [3:0] ST_RELEASE1     = 4'd2;
   localparam logic [3:0] ST_PRESS2       = 4'd3;
   localparam logic [3:0] ST_WAIT_RELEASE = 4'd4;
   localparam logic [3:0] ST_HELD         = 4'd6;
   localparam logic [3:0] ST_HELD_REL1    = 4'd7;
   localparam logic [3:0] ST_HELD_PRESS2  = 4'd8;
   localparam logic [3:0] ST_HELD_REL2    = 4'd9;
   localparam logic [3:0] ST_WAIT_PRESS   = 4'd10;

endpackage

>>> design/button_gesture_detector.sv
// Top level of the button gesture detector: config registers, stages, result register.
//
// One req transaction is one millisecond tick; req_tdata[0] is the raw
// active-low pin level. Each tick yields exactly one rsp transaction carrying
// the gesture code (0 none, 1 click, 2 double, 3 long press, 4 long release,
// 5 held click, 6 held double) and the debounced level after that tick.
// The result is registered: a tick accepted at a clock edge is on rsp in the following cycle.
// Throughput is one tick per cycle; the single result register is refilled
// in the same cycle it is drained, so req_tready stays high while rsp_tready
// is high. When the receiver stalls with a result held, req_tready drops and
// no state moves until that result is taken.
// Thresholds are to be written on the csr port (0 click, 1 press, 2 debounce)
// only while the block is idle; the block itself does not enforce this. Reset restores
// 800/1000/50 ticks, the idle state, a released level and zeroed timers, and
// empties the result register. Timers are TIMER_BITS wide and saturate.
module button_gesture_detector #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] raw_level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] gesture, [3] clean_level, [7:4] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   bgd_pkg::cfg_type cfg_ff, cfg_in;
   logic             valid_ff, valid_in;
   logic [2:0]       gesture_ff;
   logic             clean_ff;
   logic             step;
   logic             clean_next;
   logic [2:0]       gesture_next;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            bgd_pkg::REG_CLICK:    cfg_in.click_ticks    = csr_wdata;
            bgd_pkg::REG_PRESS:    cfg_in.press_ticks    = csr_wdata;
            bgd_pkg::REG_DEBOUNCE: cfg_in.debounce_ticks = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_tready = !valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign valid_in   = step || (valid_ff && !rsp_tready);

   bgd_debounce #(.TIMER_BITS(TIMER_BITS)) u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw_level      (req_tdata[0]),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .clean_next     (clean_next)
   );

   bgd_fsm #(.TIMER_BITS(TIMER_BITS)) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .up      (clean_next),
      .cfg     (cfg_ff),
      .gesture (gesture_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_ticks    <= bgd_pkg::ClickReset;
         cfg_ff.press_ticks    <= bgd_pkg::PressReset;
         cfg_ff.debounce_ticks <= bgd_pkg::DebounceReset;
         valid_ff              <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         gesture_ff <= gesture_next;
         clean_ff   <= clean_next;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, clean_ff, gesture_ff};

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result register not empty after reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(rsp_tvalid && !rsp_tready))
      else $error("tick accepted over a stalled result");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != 3'd7))
      else $error("gesture code out of range");

   a_long_press_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == bgd_pkg::GEST_LONG_PRESS) |-> !rsp_tdata[3])
      else $error("long press reported with button released");

   a_long_release_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == bgd_pkg::GEST_LONG_RELEASE) |-> rsp_tdata[3])
      else $error("long release reported with button pressed");
`endif
endmodule

>>> design/bgd_debounce.sv
// Debounce stage: quiet counter and accepted (clean) level.
module bgd_debounce #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       raw_level,
   input  logic [bgd_pkg::CfgW-1:0]   debounce_ticks,
   output logic                       clean_next
);
   localparam int unsigned CmpW = (TIMER_BITS > bgd_pkg::CfgW) ? TIMER_BITS : bgd_pkg::CfgW;

   logic [TIMER_BITS-1:0] since_change_ff, since_change_in;
   logic                  prev_raw_ff, prev_raw_in;
   logic                  stable_ff, stable_in;

   always_comb begin
      if (raw_level != prev_raw_ff) begin
         since_change_in = '0;
      end else if (since_change_ff == {TIMER_BITS{1'b1}}) begin
         since_change_in = since_change_ff;
      end else begin
         since_change_in = since_change_ff + 1'b1;
      end
      if (CmpW'(since_change_in) > CmpW'(debounce_ticks)) begin
         stable_in = raw_level;
      end else begin
         stable_in = stable_ff;
      end
      prev_raw_in = raw_level;
   end

   assign clean_next = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         since_change_ff <= '0;
         prev_raw_ff     <= 1'b1;
         stable_ff       <= 1'b1;
      end else if (step) begin
         since_change_ff <= since_change_in;
         prev_raw_ff     <= prev_raw_in;
         stable_ff       <= stable_in;
      end
   end
endmodule

>>> design/bgd_fsm.sv
// Gesture state machine with its saturating gesture timer.
module bgd_fsm #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 up,
   input  bgd_pkg::cfg_type     cfg,
   output logic [2:0]           gesture
);
   localparam int unsigned CmpW = (TIMER_BITS > bgd_pkg::CfgW) ? TIMER_BITS : bgd_pkg::CfgW;

   logic [3:0]            state_ff, state_in;
   logic [TIMER_BITS-1:0] since_start_ff, since_start_in;
   logic [TIMER_BITS-1:0] since_inc;
   logic                  past_click;
   logic                  past_press;
   logic                  restart;

   always_comb begin
      if (since_start_ff == {TIMER_BITS{1'b1}}) begin
         since_inc = since_start_ff;
      end else begin
         since_inc = since_start_ff + 1'b1;
      end
      past_click = CmpW'(since_inc) > CmpW'(cfg.click_ticks);
      past_press = CmpW'(since_inc) > CmpW'(cfg.press_ticks);

      state_in = state_ff;
      gesture  = bgd_pkg::GEST_NONE;
      restart  = 1'b0;
      case (state_ff)
         bgd_pkg::ST_IDLE: begin
            if (!up) begin
               state_in = bgd_pkg::ST_PRESS1;
               restart  = 1'b1;
            end
         end
         bgd_pkg::ST_PRESS1: begin
            if (up) begin
               state_in = bgd_pkg::ST_RELEASE1;
            end else if (past_press) begin
               gesture  = bgd_pkg::GEST_LONG_PRESS;
               state_in = bgd_pkg::ST_HELD;
            end
         end
         bgd_pkg::ST_RELEASE1: begin
            if (past_click) begin
               gesture  = bgd_pkg::GEST_CLICK;
               state_in = bgd_pkg::ST_IDLE;
            end else if (!up) begin
               state_in = bgd_pkg::ST_PRESS2;
            end
         end
         bgd_pkg::ST_PRESS2: begin
            if (past_click) begin
               state_in = bgd_pkg::ST_WAIT_RELEASE;
            end else if (up) begin
               gesture  = bgd_pkg::GEST_DOUBLE;
               state_in = bgd_pkg::ST_IDLE;
            end
         end
         bgd_pkg::ST_WAIT_RELEASE: begin
            if (up) state_in = bgd_pkg::ST_IDLE;
         end
         bgd_pkg::ST_HELD: begin
            if (up) begin
               state_in = bgd_pkg::ST_HELD_REL1;
               restart  = 1'b1;
            end
         end
         bgd_pkg::ST_HELD_REL1: begin
            if (!up) begin
               state_in = bgd_pkg::ST_HELD_PRESS2;
            end else if (past_press) begin
               gesture  = bgd_pkg::GEST_LONG_RELEASE;
               state_in = bgd_pkg::ST_IDLE;
            end
         end
         bgd_pkg::ST_HELD_PRESS2: begin
            if (past_click) begin
               gesture  = bgd_pkg::GEST_HELD_CLICK;
               state_in = bgd_pkg::ST_HELD;
            end else if (up) begin
               state_in = bgd_pkg::ST_HELD_REL2;
            end
         end
         bgd_pkg::ST_HELD_REL2: begin
            if (past_click) begin
               state_in = bgd_pkg::ST_WAIT_PRESS;
            end else if (!up) begin
               gesture  = bgd_pkg::GEST_HELD_DOUBLE;
               state_in = bgd_pkg::ST_HELD;
            end
         end
         bgd_pkg::ST_WAIT_PRESS: begin
            if (!up) state_in = bgd_pkg::ST_HELD;
         end
         default: begin
            state_in = bgd_pkg::ST_IDLE;
         end
      endcase
      since_start_in = restart ? '0 : since_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bgd_pkg::ST_IDLE;
         since_start_ff <= '0;
      end else if (step) begin
         state_ff       <= state_in;
         since_start_ff <= since_start_in;
      end
   end
endmodule
